>>> rtl/core/lcs3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs3_pkg: shared types and constants
// Sizes, op codes and the command/status bundles of the three-sequence LCS.
// ----------------------------------------------------------------------------
package lcs3_pkg;

    localparam int MAX_LEN = 32;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int SEQ_AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int ADDR_W  = 1 + 2 * LEN_W;
    localparam int CHAR_W  = 8;
    localparam int OP_W    = 2;
    localparam int LCS_W   = 6;
    localparam int LCS_MAX = (1 << LCS_W) - 1;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND_FIRST  = 2'd0,
        OP_APPEND_SECOND = 2'd1,
        OP_APPEND_THIRD  = 2'd2,
        OP_COMPUTE       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RD_DIAG  = 2'd0,
        RD_UP    = 2'd1,
        RD_NORTH = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    push;
        logic    start;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_diag;
        logic    cap_up;
        logic    write;
        logic    publish;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic boundary;
        logic last_i;
        logic last_j;
        logic last_k;
    } t_status;

endpackage
`default_nettype wire

>>> rtl/core/lcs3_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs3_datapath: sequence storage, score planes and cell update
// Holds the three sequences, the sweep counters and the two-plane score
// memory; evaluates one cell per write command and holds the result.
// ----------------------------------------------------------------------------
module lcs3_datapath (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire lcs3_pkg::t_cmd         i_cmd,
    input  wire logic [1:0]             i_op,
    input  wire logic [7:0]             i_char_value,
    output lcs3_pkg::t_status           o_status,
    output logic [5:0]                  o_lcs_length,
    output logic                        o_truncated
);
    import lcs3_pkg::*;

    logic [CHAR_W-1:0] r_first_seq  [MAX_LEN];
    logic [CHAR_W-1:0] r_second_seq [MAX_LEN];
    logic [CHAR_W-1:0] r_third_seq  [MAX_LEN];
    logic [LEN_W-1:0]  r_first_len, r_second_len, r_third_len;
    logic              r_overflow;

    logic [LEN_W-1:0]  r_i, r_j, r_k;
    logic [LEN_W-1:0]  w_im1, w_jm1, w_km1;

    logic [LEN_W-1:0]  r_planes [2**ADDR_W];
    logic [LEN_W-1:0]  r_rdata, r_diag, r_up, r_left, r_final;
    logic [ADDR_W-1:0] w_rd_addr, w_wr_addr;
    logic              w_cur, w_first_row, w_match;
    logic [LEN_W-1:0]  w_diag, w_up, w_m1, w_m2, n_cell;
    logic [LCS_W-1:0]  w_lcs;
    t_op               w_op;

    assign w_op  = t_op'(i_op);
    assign w_im1 = r_i - 1'b1;
    assign w_jm1 = r_j - 1'b1;
    assign w_km1 = r_k - 1'b1;
    assign w_cur = r_i[0];
    assign w_first_row = (r_i == LEN_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_len  <= '0;
            r_second_len <= '0;
            r_third_len  <= '0;
            r_overflow   <= 1'b0;
        end else if (i_cmd.publish) begin
            r_first_len  <= '0;
            r_second_len <= '0;
            r_third_len  <= '0;
            r_overflow   <= 1'b0;
        end else if (i_cmd.push) begin
            unique case (w_op)
                OP_APPEND_FIRST: begin
                    if (r_first_len == LEN_W'(MAX_LEN)) r_overflow <= 1'b1;
                    else r_first_len <= r_first_len + 1'b1;
                end
                OP_APPEND_SECOND: begin
                    if (r_second_len == LEN_W'(MAX_LEN)) r_overflow <= 1'b1;
                    else r_second_len <= r_second_len + 1'b1;
                end
                OP_APPEND_THIRD: begin
                    if (r_third_len == LEN_W'(MAX_LEN)) r_overflow <= 1'b1;
                    else r_third_len <= r_third_len + 1'b1;
                end
                OP_COMPUTE: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            if (w_op == OP_APPEND_FIRST && r_first_len != LEN_W'(MAX_LEN))
                r_first_seq[r_first_len[SEQ_AW-1:0]] <= i_char_value;
            if (w_op == OP_APPEND_SECOND && r_second_len != LEN_W'(MAX_LEN))
                r_second_seq[r_second_len[SEQ_AW-1:0]] <= i_char_value;
            if (w_op == OP_APPEND_THIRD && r_third_len != LEN_W'(MAX_LEN))
                r_third_seq[r_third_len[SEQ_AW-1:0]] <= i_char_value;
        end
    end

    // sweep counters: k fastest, then j, then i
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
        end else if (i_cmd.start) begin
            r_i <= LEN_W'(1);
            r_j <= '0;
            r_k <= '0;
        end else if (i_cmd.write) begin
            if (!o_status.last_k) begin
                r_k <= r_k + 1'b1;
            end else begin
                r_k <= '0;
                if (!o_status.last_j) begin
                    r_j <= r_j + 1'b1;
                end else begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_DIAG:  w_rd_addr = {~w_cur, w_jm1, w_km1};
            RD_UP:    w_rd_addr = {~w_cur, r_j, r_k};
            RD_NORTH: w_rd_addr = {w_cur, w_jm1, r_k};
            default:  w_rd_addr = {w_cur, r_j, r_k};
        endcase
    end

    assign w_wr_addr = {w_cur, r_j, r_k};

    // previous plane reads as zero on the first row
    assign w_diag  = w_first_row ? '0 : r_diag;
    assign w_up    = w_first_row ? '0 : r_up;
    assign w_match = (r_first_seq[w_im1[SEQ_AW-1:0]] == r_second_seq[w_jm1[SEQ_AW-1:0]])
                  && (r_first_seq[w_im1[SEQ_AW-1:0]] == r_third_seq[w_km1[SEQ_AW-1:0]]);
    assign w_m1    = (w_up > r_rdata) ? w_up : r_rdata;
    assign w_m2    = (w_m1 > r_left) ? w_m1 : r_left;

    always_comb begin
        if (o_status.boundary) n_cell = '0;
        else if (w_match)      n_cell = w_diag + 1'b1;
        else                   n_cell = w_m2;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) r_planes[w_wr_addr] <= n_cell;
        if (i_cmd.rd_en) r_rdata <= r_planes[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_diag) r_diag <= r_rdata;
        if (i_cmd.cap_up)   r_up   <= r_rdata;
        if (i_cmd.write) begin
            r_left  <= n_cell;
            r_final <= n_cell;
        end
    end

    assign w_lcs = (32'(r_final) > 32'(LCS_MAX)) ? LCS_W'(LCS_MAX) : LCS_W'(r_final);

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            o_lcs_length <= o_status.empty ? '0 : w_lcs;
            o_truncated  <= r_overflow;
        end
    end

    assign o_status.empty    = (r_first_len == '0) || (r_second_len == '0)
                            || (r_third_len == '0);
    assign o_status.boundary = (r_j == '0) || (r_k == '0);
    assign o_status.last_i   = (r_i == r_first_len);
    assign o_status.last_j   = (r_j == r_second_len);
    assign o_status.last_k   = (r_k == r_third_len);

endmodule
`default_nettype wire

>>> rtl/core/lcs3_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs3_ctrl: sweep sequencer
// Accepts requests, steps the datapath through the score table cell by
// cell and hands the result to the output register.
// ----------------------------------------------------------------------------
module lcs3_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic [1:0]             i_op,
    input  wire logic                   i_out_stall,
    input  wire lcs3_pkg::t_status      i_status,
    output lcs3_pkg::t_cmd              o_cmd,
    output logic                        o_in_stall,
    output logic                        o_out_valid
);
    import lcs3_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL,
        ST_RD_UP,
        ST_RD_NORTH,
        ST_WRITE,
        ST_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_accept, w_compute, w_out_free, w_last_cell;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_compute   = (t_op'(i_op) == OP_COMPUTE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_last_cell = i_status.last_i && i_status.last_j && i_status.last_k;

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = RD_DIAG;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.push  = w_accept && !w_compute;
                o_cmd.start = w_accept && w_compute && !i_status.empty;
            end
            ST_CELL: begin
                o_cmd.write = i_status.boundary;
                o_cmd.rd_en = !i_status.boundary;
            end
            ST_RD_UP: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = RD_UP;
                o_cmd.cap_diag = 1'b1;
            end
            ST_RD_NORTH: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_NORTH;
                o_cmd.cap_up = 1'b1;
            end
            ST_WRITE: o_cmd.write = 1'b1;
            ST_DONE:  o_cmd.publish = w_out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.publish)     r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && w_compute)
                        r_state <= i_status.empty ? ST_DONE : ST_CELL;
                end
                ST_CELL: begin
                    if (!i_status.boundary)  r_state <= ST_RD_UP;
                    else if (w_last_cell)    r_state <= ST_DONE;
                end
                ST_RD_UP:    r_state <= ST_RD_NORTH;
                ST_RD_NORTH: r_state <= ST_WRITE;
                ST_WRITE:    r_state <= w_last_cell ? ST_DONE : ST_CELL;
                ST_DONE: begin
                    if (w_out_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.push, o_cmd.start, o_cmd.write, o_cmd.publish}))
        else $error("more than one datapath command at once");

    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> (!r_out_valid || !i_out_stall))
        else $error("result published over a pending result");

    a_start_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == ST_CELL))
        else $error("sweep did not begin after start");

    a_write_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> ($past(r_state) == ST_RD_NORTH))
        else $error("cell write without its neighbor reads");
`endif

endmodule
`default_nettype wire

>>> rtl/core/lcs_length_three_sequences.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_length_three_sequences: LCS length of three byte sequences
// Appends characters to three sequences and, on a compute request, sweeps
// the three-dimensional score table over two rolling planes.
//
//   channel | direction | handshake                | payload
//   in      | input     | i_in_valid / o_in_stall  | i_op, i_char_value
//   out     | output    | o_out_valid / i_out_stall| o_lcs_length, o_truncated
//
// Append requests are accepted while the sequencer is idle.
// A compute request sweeps the table cell by cell through the
// single-read-port score memory (three reads per non-boundary table cell).
// A compute with any empty sequence skips the sweep and returns zero.
// Appends continue while a result waits; a compute finishes only once the
// output register is free. Synchronous active-low reset empties all sequences.
// ----------------------------------------------------------------------------
module lcs_length_three_sequences (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_char_value,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [5:0]      o_lcs_length,
    output logic            o_truncated
);
    import lcs3_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    lcs3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    lcs3_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_op         (i_op),
        .i_char_value (i_char_value),
        .o_status     (w_status),
        .o_lcs_length (o_lcs_length),
        .o_truncated  (o_truncated)
    );

endmodule
`default_nettype wire
